// ===== src/lpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfl_pkg
// Shared types and constants for the length-prefixed flash page loader.
// ----------------------------------------------------------------------------
package lpfl_pkg;

	localparam int PAGE_BYTES_DEF = 128;
	localparam logic [7:0] PAD_BYTE = 8'hFF;
	localparam logic [1:0] HDR_BYTES = 2'd2;

	typedef enum logic [2:0] {
		ST_IN   = 3'b001,
		ST_READ = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic rd_word;
		logic word_done;
	} lpfl_cmd_t;

	typedef struct packed {
		logic flush;
		logic last_word;
	} lpfl_sts_t;

endpackage

// ===== src/lpfl_ram.sv =====
// ----------------------------------------------------------------------------
// lpfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/lpfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpfl_ctrl
// Sequencer: takes bytes, then walks one read/emit pair per word of a flush.
// ----------------------------------------------------------------------------
module lpfl_ctrl
	import lpfl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  lpfl_sts_t sts,
	output lpfl_cmd_t cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IN: begin
				if (in_valid && sts.flush) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_stall) state_d = sts.last_word ? ST_IN : ST_READ;
			end
			default: begin
				state_d = ST_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall      = (state_q != ST_IN);
	assign out_valid     = (state_q == ST_EMIT);
	assign cmd.take_byte = (state_q == ST_IN) && in_valid;
	assign cmd.rd_word   = (state_q == ST_READ);
	assign cmd.word_done = (state_q == ST_EMIT) && !out_stall;

endmodule

// ===== src/lpfl_dp.sv =====
// ----------------------------------------------------------------------------
// lpfl_dp
// Datapath: length header, page buffer in even/odd byte banks, word fills.
// ----------------------------------------------------------------------------
module lpfl_dp
	import lpfl_pkg::*;
#(
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lpfl_cmd_t   cmd,
	output lpfl_sts_t   sts,
	input  logic [7:0]  data_byte,
	output logic [15:0] flash_byte_address,
	output logic [15:0] fill_word,
	output logic        page_first,
	output logic        page_last,
	output logic        session_done
);

	localparam int WORDS = (PAGE_BYTES + 1) / 2;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int FW    = $clog2(PAGE_BYTES + 1);
	localparam int CW    = (AW + 2 > FW) ? AW + 2 : FW;

	logic [1:0]    hdr_cnt_q;
	logic [15:0]   img_len_q;
	logic [FW-1:0] fill_q;
	logic [16:0]   page_off_q;
	logic [AW-1:0] word_idx_q;
	logic          fin_q;

	logic          is_image;
	logic [FW-1:0] fill_next;
	logic [17:0]   done_sum;
	logic          finished;
	logic [AW-1:0] wr_addr;
	logic          we_even, we_odd;
	logic [7:0]    rd_even, rd_odd;
	logic [CW-1:0] pos_lo, pos_hi;
	logic          last_w;

	assign is_image  = (hdr_cnt_q == HDR_BYTES);
	assign fill_next = fill_q + FW'(1);
	assign done_sum  = {1'b0, page_off_q} + 18'(fill_next);
	assign finished  = (done_sum >= 18'(img_len_q));
	assign sts.flush = is_image && ((fill_next >= FW'(PAGE_BYTES)) || finished);

	assign wr_addr = AW'(fill_q >> 1);
	assign we_even = cmd.take_byte && is_image && !fill_q[0];
	assign we_odd  = cmd.take_byte && is_image && fill_q[0];

	lpfl_ram #(.WIDTH(8), .DEPTH(WORDS), .AW(AW)) u_ram_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (wr_addr),
		.wdata (data_byte),
		.re    (cmd.rd_word),
		.raddr (word_idx_q),
		.rdata (rd_even)
	);

	lpfl_ram #(.WIDTH(8), .DEPTH(WORDS), .AW(AW)) u_ram_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (wr_addr),
		.wdata (data_byte),
		.re    (cmd.rd_word),
		.raddr (word_idx_q),
		.rdata (rd_odd)
	);

	assign pos_lo = CW'({word_idx_q, 1'b0});
	assign pos_hi = pos_lo + CW'(1);
	assign last_w = (word_idx_q == AW'(WORDS - 1));

	assign sts.last_word      = last_w;
	assign flash_byte_address = page_off_q[15:0] + 16'(pos_lo);
	assign fill_word[7:0]     = (pos_lo < CW'(fill_q)) ? rd_even : PAD_BYTE;
	assign fill_word[15:8]    = (pos_hi < CW'(fill_q)) ? rd_odd : PAD_BYTE;
	assign page_first         = (word_idx_q == '0);
	assign page_last          = last_w;
	assign session_done       = last_w && fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q  <= '0;
			img_len_q  <= '0;
			fill_q     <= '0;
			page_off_q <= '0;
			word_idx_q <= '0;
			fin_q      <= 1'b0;
		end else if (cmd.take_byte) begin
			if (!is_image) begin
				if (hdr_cnt_q == 2'd0) begin
					img_len_q[15:8] <= data_byte;
				end else begin
					img_len_q[7:0] <= data_byte;
				end
				hdr_cnt_q <= hdr_cnt_q + 2'd1;
			end else begin
				fill_q     <= fill_next;
				fin_q      <= finished;
				word_idx_q <= '0;
			end
		end else if (cmd.word_done) begin
			if (last_w) begin
				fill_q     <= '0;
				word_idx_q <= '0;
				if (fin_q) begin
					hdr_cnt_q  <= '0;
					img_len_q  <= '0;
					page_off_q <= '0;
				end else begin
					page_off_q <= page_off_q + 17'(PAGE_BYTES);
				end
			end else begin
				word_idx_q <= word_idx_q + AW'(1);
			end
		end
	end

endmodule

// ===== src/length_prefixed_flash_page_loader_top.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_flash_page_loader_top
// Byte stream in (two-byte big-endian length, then image); page flushes out
// as runs of little-endian word fills with 0xFF padding.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_stall  | data_byte
//  output  | out_valid / out_stall| flash_byte_address, fill_word, page_first,
//          |                      | page_last, session_done
//
//  A byte that does not end a page is taken without stalling the input.
//  A flush emits (PAGE_BYTES+1)/2 words, each a registered read of the page
//  buffer banks in ST_READ, then output in ST_EMIT; out_stall holds the word.
//  No byte is taken during a flush.
//  arst_n clears all counters; the page buffer needs no clearing.
// ----------------------------------------------------------------------------
module length_prefixed_flash_page_loader_top
	import lpfl_pkg::*;
#(
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] flash_byte_address,
	output logic [15:0] fill_word,
	output logic        page_first,
	output logic        page_last,
	output logic        session_done
);

	lpfl_cmd_t cmd;
	lpfl_sts_t sts;

	lpfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpfl_dp #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.data_byte          (data_byte),
		.flash_byte_address (flash_byte_address),
		.fill_word          (fill_word),
		.page_first         (page_first),
		.page_last          (page_last),
		.session_done       (session_done)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("byte taken during flush");

	a_flush_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_byte && sts.flush) |=> (in_stall && !out_valid))
		else $error("flush did not start with a read");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_byte && sts.flush) |=> ##1 (out_valid && page_first))
		else $error("flush run does not open on first word");

	a_return_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && page_last) |=> !in_stall)
		else $error("loader not idle after last word");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed flash page loader. Byte
// sessions (length header, image bytes) go in with random gaps; every word
// fill that comes out is matched field by field against a page-flush
// predictor kept in step with the accepted input items.
// ----------------------------------------------------------------------------
module tb;
	import lpfl_pkg::*;

	localparam int PAGE       = PAGE_BYTES_DEF;
	localparam int PAGE_WORDS = (PAGE + 1) / 2;
	localparam int QUIET_TAIL = 40;
	localparam int STALL_MAX  = 4000;
	localparam int DRAIN_WAIT = 400;

	typedef struct {
		logic [7:0] b;
		bit         drain;
	} stream_byte_t;

	typedef struct {
		logic [15:0] addr;
		logic [15:0] word;
		logic        first;
		logic        last;
		logic        done;
	} word_fill_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] flash_byte_address;
	logic [15:0] fill_word;
	logic        page_first;
	logic        page_last;
	logic        session_done;

	stream_byte_t byte_stream_q[$];
	word_fill_t   fill_words_q[$];
	stream_byte_t nxt_byte;
	word_fill_t   got_fill;

	// predictor state
	logic [1:0]  hdr_cnt;
	logic [15:0] img_len;
	logic [7:0]  page_buf[PAGE];
	int          buf_fill;
	logic [16:0] page_off;

	int errors;
	int gap_left;
	int idle_pct;
	int sent_cnt;
	int stall_left;
	int stall_pct;
	int quiet_cycles;

	length_prefixed_flash_page_loader_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.data_byte          (data_byte),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.flash_byte_address (flash_byte_address),
		.fill_word          (fill_word),
		.page_first         (page_first),
		.page_last          (page_last),
		.session_done       (session_done)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic absorb_byte(input logic [7:0] b);
		word_fill_t wf;
		bit         finished;
		int         pos;
		logic [7:0] lo;
		logic [7:0] hi;
		if (hdr_cnt < HDR_BYTES) begin
			if (hdr_cnt == 2'd0)
				img_len[15:8] = b;
			else
				img_len[7:0] = b;
			hdr_cnt = hdr_cnt + 2'd1;
			return;
		end
		if (buf_fill < PAGE)
			page_buf[buf_fill] = b;
		buf_fill++;
		finished = (int'(page_off) + buf_fill) >= int'(img_len);
		if (buf_fill < PAGE && !finished)
			return;
		for (int k = 0; k < PAGE_WORDS; k++) begin
			pos = 2 * k;
			lo = (pos < buf_fill && pos < PAGE) ? page_buf[pos] : PAD_BYTE;
			hi = (pos + 1 < buf_fill && pos + 1 < PAGE) ? page_buf[pos + 1] : PAD_BYTE;
			wf.addr  = 16'(page_off + 17'(pos));
			wf.word  = {hi, lo};
			wf.first = (k == 0);
			wf.last  = (k == PAGE_WORDS - 1);
			wf.done  = finished && (k == PAGE_WORDS - 1);
			fill_words_q.push_back(wf);
		end
		buf_fill = 0;
		page_off = page_off + 17'(PAGE);
		if (finished) begin
			hdr_cnt  = '0;
			img_len  = '0;
			page_off = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= '0;
			gap_left  <= 0;
			idle_pct  <= 0;
			sent_cnt  <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid && byte_stream_q.size() >= QUIET_TAIL
					&& $urandom_range(0, 99) < idle_pct) begin
				in_valid <= 1'b0;
				gap_left <= $urandom_range(0, 12);
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (byte_stream_q.size() > 0 && !(byte_stream_q[0].drain
					&& (in_valid || fill_words_q.size() > 0))) begin
				nxt_byte = byte_stream_q.pop_front();
				in_valid  <= 1'b1;
				data_byte <= nxt_byte.b;
				sent_cnt  <= sent_cnt + 1;
				if (sent_cnt % 64 == 0)
					idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 45);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted bytes, check accepted word fills
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			stall_pct  <= 20;
			hdr_cnt    = '0;
			img_len    = '0;
			buf_fill   = 0;
			page_off   = '0;
		end else begin
			if (in_valid && !in_stall)
				absorb_byte(data_byte);
			if (out_valid && !out_stall) begin
				if (fill_words_q.size() == 0) begin
					$error("unexpected word fill: address %h word %h",
						flash_byte_address, fill_word);
					errors++;
				end else begin
					got_fill = fill_words_q.pop_front();
					check_field("flash_byte_address", got_fill.addr, flash_byte_address);
					check_field("fill_word", got_fill.word, fill_word);
					check_field("page_first", 16'(got_fill.first), 16'(page_first));
					check_field("page_last", 16'(got_fill.last), 16'(page_last));
					check_field("session_done", 16'(got_fill.done), 16'(session_done));
				end
				if (page_first)
					stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			end
			if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (out_stall) begin
				out_stall <= 1'b0;
			end else if (byte_stream_q.size() >= QUIET_TAIL
					&& $urandom_range(0, 99) < stall_pct) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 12);
			end
		end
	end

	// watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("length_prefixed_flash_page_loader_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_byte(input logic [7:0] b, input bit drain);
		stream_byte_t sb;
		sb.b     = b;
		sb.drain = drain;
		byte_stream_q.push_back(sb);
	endtask

	// header then 'body' random image bytes
	task automatic push_session(input int len, input int body, input bit drain);
		push_byte(8'(len >> 8), drain);
		push_byte(8'(len), 1'b0);
		for (int i = 0; i < body; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin
		int total;
		int len;
		int r;
		errors    = 0;
		arst_n    = 1'b0;

		// zero length: first image byte closes the session
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1); push_byte(8'h02, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
		// odd length: padding in the high byte of the last written word
		push_byte(8'h00, 1'b0); push_byte(8'h03, 1'b0);
		push_byte(8'hA5, 1'b0); push_byte(8'h5A, 1'b0); push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h04, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0); push_byte(8'h7F, 1'b0);

		total = 0;
		while (total < 70) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				len = 0;
			else if (r < 45)
				len = $urandom_range(1, 24);
			else if (r < 60)
				case ($urandom_range(0, 3))
					0: len = 127;
					1: len = 128;
					2: len = 129;
					default: len = 256;
				endcase
			else
				len = $urandom_range(25, 260);
			push_session(len, (len == 0) ? 1 : len, $urandom_range(0, 5) == 0);
			total += ((len == 0) ? 1 : len) + 2;
		end
		// maximum length header; one full page, session left open
		push_session(16'hFFFF, PAGE + 12, 1'b1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_stream_q.size() > 0 || in_valid)
			@(posedge clk);
		while (fill_words_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0)
			$display("length_prefixed_flash_page_loader_top regression: pass");
		else
			$display("length_prefixed_flash_page_loader_top regression: fail");
		$finish;
	end

endmodule
